// File: src/stq_pkg.sv
package stq_pkg;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W       = $clog2(SLOTS + 1);
  localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned TIME_W      = 32;

  localparam logic       CMD_START = 1'b0;
  localparam logic       CMD_TICK  = 1'b1;

  localparam logic [1:0] KIND_FIRED    = 2'd0;
  localparam logic [1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_FULL     = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  timer_id;
    logic [15:0] period;
    logic        periodic;
  } stq_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] fired_id;
    logic       last;
  } stq_out_t;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [15:0]       period;
    logic              periodic;
    logic [7:0]        ident;
  } stq_entry_t;

endpackage

// File: src/stq_front.sv
module stq_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  stq_pkg::stq_in_t in_data_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output stq_pkg::stq_in_t cmd_data_o
);
  import stq_pkg::*;

  // two-deep command queue; period of zero is normalised to one on entry
  stq_in_t    buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  stq_in_t    norm;

  always_comb begin
    norm = in_data_i;
    if (in_data_i.period == 16'd0) begin
      norm.period = 16'd1;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_data_o  = buf_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= norm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: src/stq_back.sv
module stq_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  stq_pkg::stq_in_t  cmd_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stq_pkg::stq_out_t out_data_o
);
  import stq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_INSERT, S_CHECK, S_POP, S_REKEY, S_EMIT
  } state_e;

  localparam logic [TIME_W-1:0] HALF = {1'b1, {(TIME_W-1){1'b0}}};

  state_e            state_q, state_d;
  stq_entry_t        slot_q [SLOTS];
  stq_entry_t        new_q, new_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [TIME_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [RES_W-1:0]  n_q, n_d;
  logic              tick_q, tick_d;
  logic              pend_q, pend_d;
  logic              cont_q, cont_d;
  stq_out_t          res_q, res_d;
  logic              out_valid_q, out_valid_d;
  stq_out_t          out_q, out_d;
  logic [TIME_W-1:0] cur_key, head_age;
  logic              cont_now, do_insert, do_pop, emit;

  assign cur_key  = (slot_q[pos_q].deadline - now_q) ^ HALF;
  assign head_age = now_q - slot_q[0].deadline;
  assign cont_now = (n_q < RES_W'(MAX_RESULTS)) && (occ_q != '0) && !head_age[TIME_W-1];

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d   = state_q;
    new_d     = new_q;
    now_d     = now_q;
    key_d     = key_q;
    occ_d     = occ_q;
    pos_d     = pos_q;
    n_d       = n_q;
    tick_d    = tick_q;
    pend_d    = pend_q;
    cont_d    = cont_q;
    res_d     = res_q;
    do_insert = 1'b0;
    do_pop    = 1'b0;
    emit      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_data_i.cmd == CMD_TICK) begin
            now_d   = now_q + TIME_W'(1);
            n_d     = '0;
            pend_d  = 1'b0;
            tick_d  = 1'b1;
            state_d = S_CHECK;
          end else if (occ_q == CNT_W'(SLOTS)) begin
            res_d   = '{kind: KIND_FULL, fired_id: cmd_data_i.timer_id, last: 1'b1};
            cont_d  = 1'b0;
            tick_d  = 1'b0;
            state_d = S_EMIT;
          end else begin
            new_d   = '{deadline: now_q + TIME_W'(cmd_data_i.period),
                        period:   cmd_data_i.period,
                        periodic: cmd_data_i.periodic,
                        ident:    cmd_data_i.timer_id};
            key_d   = HALF | TIME_W'(cmd_data_i.period);
            pos_d   = '0;
            tick_d  = 1'b0;
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if ((CNT_W'(pos_q) < occ_q) && (cur_key <= key_q)) begin
          pos_d = pos_q + SLOT_W'(1);
        end else begin
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        do_insert = 1'b1;
        occ_d     = occ_q + CNT_W'(1);
        if (tick_q) begin
          state_d = S_CHECK;
        end else begin
          res_d   = '{kind: KIND_ACCEPTED, fired_id: new_q.ident, last: 1'b1};
          cont_d  = 1'b0;
          state_d = S_EMIT;
        end
      end
      S_CHECK: begin
        cont_d = cont_now;
        if (pend_q) begin
          res_d.last = !cont_now;
          state_d    = S_EMIT;
        end else if (cont_now) begin
          state_d = S_POP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        do_pop         = 1'b1;
        new_d          = slot_q[0];
        new_d.deadline = slot_q[0].deadline + TIME_W'(slot_q[0].period);
        occ_d          = occ_q - CNT_W'(1);
        n_d            = n_q + RES_W'(1);
        pend_d         = 1'b1;
        res_d          = '{kind: KIND_FIRED, fired_id: slot_q[0].ident, last: 1'b0};
        state_d        = slot_q[0].periodic ? S_REKEY : S_CHECK;
      end
      S_REKEY: begin
        key_d   = (new_q.deadline - now_q) ^ HALF;
        pos_d   = '0;
        state_d = S_SEARCH;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          emit    = 1'b1;
          pend_d  = 1'b0;
          state_d = cont_q ? S_POP : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_d       = emit ? res_q : out_q;
    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  // slot store: insert shifts the tail up, pop shifts everything down by one
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (do_insert) begin
        if (SLOT_W'(i) == pos_q) begin
          slot_q[i] <= new_q;
        end else if ((i > 0) && (SLOT_W'(i) > pos_q) && (CNT_W'(i) <= occ_q)) begin
          slot_q[i] <= slot_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_pop && (i < SLOTS - 1)) begin
        slot_q[i] <= slot_q[(i < SLOTS - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    key_q <= key_d;
    res_q <= res_d;
    out_q <= out_d;
    pos_q <= pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      occ_q       <= '0;
      n_q         <= '0;
      tick_q      <= 1'b0;
      pend_q      <= 1'b0;
      cont_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      occ_q       <= occ_d;
      n_q         <= n_d;
      tick_q      <= tick_d;
      pend_q      <= pend_d;
      cont_q      <= cont_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(SLOTS)) else $error("occupancy above slot count");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INSERT |-> occ_q < CNT_W'(SLOTS)) else $error("insert into full queue");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> CNT_W'(pos_q) <= occ_q) else $error("search past tail");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> (occ_q != '0) && (n_q < RES_W'(MAX_RESULTS)))
    else $error("pop without due entry");

  a_emit_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && tick_q |-> pend_q) else $error("tick emit with nothing popped");

endmodule

// File: src/sorted_timer_queue_top.sv
// Sorted timer queue: start transfers (cmd 0) insert a timer due at now+period behind all
// entries due no later, answering one accepted or full result with last set; tick transfers
// (cmd 1) advance time by one and report each due timer in deadline order, at most sixteen
// per tick, re-queueing periodic ones. Input transfers pass through a two-deep command queue.
// A start walks the queued entries due no later than the new one before inserting it; a tick
// pops each due timer and walks the slots again to re-insert a periodic one. The slot walk
// compares one slot per cycle.
module sorted_timer_queue_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  stq_pkg::stq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output stq_pkg::stq_out_t out_data_o
);
  import stq_pkg::*;

  logic    cmd_valid, cmd_ready;
  stq_in_t cmd_data;

  stq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_data_o  (cmd_data)
  );

  stq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_data_i  (cmd_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/tb.sv
module tb;
  import stq_pkg::*;

  localparam int LIMIT          = 400000;
  localparam int RAND_PER_PHASE = 36;
  localparam int TAIL           = 64;

  // n_typed: -1 take the predictor, 0 no result, 1 one result of the given kind
  typedef struct {
    stq_in_t    stim;
    int         n_typed;
    logic [1:0] kind;
  } dir_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  stq_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  stq_out_t out_data;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int errors      = 0;
  int cycles      = 0;
  int n_sent      = 0;
  int n_fired     = 0;
  int n_accepted  = 0;
  int n_full      = 0;
  int burst       = 0;
  int max_burst   = 0;

  logic [TIME_W-1:0] now_ticks = '0;
  stq_entry_t        timers_q[$];
  stq_out_t          step_results[$];
  stq_out_t          events_due[$];
  dir_row_t          dir_tab[$];

  sorted_timer_queue_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, events_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
  endtask

  always @(posedge clk) begin
    stq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      case (out_data.kind)
        KIND_FIRED:    n_fired++;
        KIND_ACCEPTED: n_accepted++;
        default:       n_full++;
      endcase
      burst = out_data.last ? 0 : burst + 1;
      if (burst > max_burst) max_burst = burst;
      if (events_due.size() == 0) begin
        report_mismatch("unexpected result, id", int'(out_data.fired_id), -1);
      end else begin
        want = events_due.pop_front();
        if (out_data.kind != want.kind)
          report_mismatch("kind", int'(out_data.kind), int'(want.kind));
        if (out_data.fired_id != want.fired_id)
          report_mismatch("fired_id", int'(out_data.fired_id), int'(want.fired_id));
        if (out_data.last != want.last)
          report_mismatch("last", int'(out_data.last), int'(want.last));
      end
    end
  end

  // signed distance from now, offset so that an unsigned compare orders deadlines
  function automatic logic [31:0] order_of(input logic [31:0] dl);
    return dl - now_ticks + 32'h8000_0000;
  endfunction

  function automatic logic due_now(input logic [31:0] dl);
    logic [31:0] gap;
    gap = now_ticks - dl;
    return gap < 32'h8000_0000;
  endfunction

  function automatic void queue_timer(input stq_entry_t e);
    logic [31:0] k;
    int          pos;
    k   = order_of(e.deadline);
    pos = 0;
    while (pos < timers_q.size() && order_of(timers_q[pos].deadline) <= k) pos++;
    timers_q.insert(pos, e);
  endfunction

  function automatic void predict_timer_step(input stq_in_t it);
    stq_entry_t  e;
    stq_out_t    r;
    logic [15:0] per;
    step_results.delete();
    per = (it.period == 16'd0) ? 16'd1 : it.period;
    if (it.cmd == CMD_START) begin
      r.fired_id = it.timer_id;
      r.last     = 1'b1;
      if (timers_q.size() >= SLOTS) begin
        r.kind = KIND_FULL;
      end else begin
        r.kind     = KIND_ACCEPTED;
        e.deadline = now_ticks + per;
        e.period   = per;
        e.periodic = it.periodic;
        e.ident    = it.timer_id;
        queue_timer(e);
      end
      step_results.push_back(r);
    end else begin
      now_ticks = now_ticks + 1;
      while (step_results.size() < MAX_RESULTS && timers_q.size() > 0 &&
             due_now(timers_q[0].deadline)) begin
        e = timers_q.pop_front();
        if (e.period == 16'd0) e.period = 16'd1;
        if (e.periodic) begin
          e.deadline = e.deadline + e.period;
          queue_timer(e);
        end
        r.kind     = KIND_FIRED;
        r.fired_id = e.ident;
        r.last     = 1'b0;
        step_results.push_back(r);
      end
      if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic send_item(input stq_in_t it, input int n_typed, input logic [1:0] kind);
    stq_out_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    predict_timer_step(it);
    if (n_typed < 0) begin
      foreach (step_results[i]) events_due.push_back(step_results[i]);
    end else if (n_typed == 1) begin
      r.kind     = kind;
      r.fired_id = it.timer_id;
      r.last     = 1'b1;
      events_due.push_back(r);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  function automatic dir_row_t dir_row(input logic cmd, input logic [7:0] id,
                                       input logic [15:0] per, input logic pd,
                                       input int n_typed, input logic [1:0] kind);
    dir_row_t row;
    row.stim.cmd      = cmd;
    row.stim.timer_id = id;
    row.stim.period   = per;
    row.stim.periodic = pd;
    row.n_typed       = n_typed;
    row.kind          = kind;
    return row;
  endfunction

  function automatic stq_in_t rand_item();
    stq_in_t it;
    it.cmd      = ($urandom_range(99) < 55) ? CMD_TICK : CMD_START;
    it.timer_id = 8'($urandom_range(255, 0));
    it.periodic = ($urandom_range(99) < 12);
    // long periods hold a slot for the rest of the run, so keep them rare and one-shot
    if ($urandom_range(99) < 4) begin
      it.period   = 16'($urandom_range(65535, 0));
      it.periodic = 1'b0;
    end else begin
      it.period = 16'($urandom_range(6, 0));
    end
    return it;
  endfunction

  initial begin
    dir_tab.push_back(dir_row(CMD_TICK,  8'h00, 16'h0001, 1'b0, 0, KIND_FIRED));
    dir_tab.push_back(dir_row(CMD_START, 8'h00, 16'h0000, 1'b0, 1, KIND_ACCEPTED));
    dir_tab.push_back(dir_row(CMD_TICK,  8'hFF, 16'hFFFF, 1'b1, -1, KIND_FIRED));
    dir_tab.push_back(dir_row(CMD_START, 8'hFF, 16'hFFFF, 1'b1, 1, KIND_ACCEPTED));
    // fill the queue with equal deadlines; a few are periodic
    for (int i = 1; i < 16; i++)
      dir_tab.push_back(dir_row(CMD_START, i[7:0], 16'd2, (i % 5 == 0), 1, KIND_ACCEPTED));
    dir_tab.push_back(dir_row(CMD_START, 8'hAA, 16'h5555, 1'b1, 1, KIND_FULL));
    repeat (4) dir_tab.push_back(dir_row(CMD_TICK, 8'h00, 16'h0001, 1'b0, -1, KIND_FIRED));

    tx_idle_pct = 33;
    rx_idle_pct = 73;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i].stim, dir_tab[i].n_typed, dir_tab[i].kind);

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        tx_idle_pct = 73;
        rx_idle_pct = 33;
      end
      if (ph == 2) begin
        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      repeat (RAND_PER_PHASE) send_item(rand_item(), -1, KIND_FIRED);
    end

    drain_results();
    $display("%0d transfers in; %0d fired, %0d accepted, %0d rejected as full",
             n_sent, n_fired, n_accepted, n_full);
    $display("largest burst from one tick: %0d timers, %0d mismatches", max_burst + 1, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
src/stq_pkg.sv
src/stq_front.sv
src/stq_back.sv
src/sorted_timer_queue_top.sv
tb/tb.sv
